FILE: rtl/core/efd_pkg.sv
package efd_pkg;

    // line markers and escape flip mask
    localparam logic [7:0] MARK_START = 8'h7E;
    localparam logic [7:0] MARK_ESC   = 8'h7D;
    localparam logic [7:0] MARK_END   = 8'h7F;
    localparam logic [7:0] ESC_FLIP   = 8'h20;

    // frame size limits
    localparam int         STORE_DEPTH_DEF = 64;
    localparam int         MAX_FRAME       = 64;
    localparam logic [6:0] LIMIT_RESET     = 7'd64;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_HOLD
    } t_state;

    // result of the shared count and compare unit
    typedef struct packed {
        logic [6:0] sum;
        logic       reach;
        logic       hit;
    } t_cnt_res;

endpackage

FILE: rtl/core/efd_store.sv
module efd_store #(
    parameter  int MEM_DEPTH = efd_pkg::STORE_DEPTH_DEF,
    localparam int ADDR_W    = $clog2(MEM_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/efd_cnt_unit.sv
module efd_cnt_unit (
    input  logic              [6:0] i_operand,
    input  logic              [6:0] i_bound,
    output efd_pkg::t_cnt_res       o_res
);

    logic [6:0] sum;

    // increment and compare against the bound
    assign sum         = i_operand + 7'd1;
    assign o_res.sum   = sum;
    assign o_res.reach = (sum >= i_bound);
    assign o_res.hit   = (sum == i_bound);

endmodule

FILE: rtl/core/efd_seq.sv
module efd_seq #(
    parameter  int MEM_DEPTH = efd_pkg::STORE_DEPTH_DEF,
    localparam int ADDR_W    = $clog2(MEM_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [6:0]        i_limit,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [5:0]        o_byte_index,
    output logic              o_frame_last,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [7:0]        o_wdata,
    output logic [ADDR_W-1:0] o_raddr
);

    efd_pkg::t_state   r_state, n_state;
    logic [6:0]        r_len, n_len;
    logic [6:0]        r_idx, n_idx;
    logic              r_esc, n_esc;
    logic              is_ordinary;
    logic [6:0]        cnt_operand;
    logic [6:0]        cnt_bound;
    efd_pkg::t_cnt_res cnt;

    // shared unit: length update while collecting, index step and last-byte check on readout
    assign cnt_operand = (r_state == efd_pkg::ST_IDLE) ? r_len : r_idx;
    assign cnt_bound   = (r_state == efd_pkg::ST_IDLE) ? i_limit : r_len;

    efd_cnt_unit u_cnt (
        .i_operand (cnt_operand),
        .i_bound   (cnt_bound),
        .o_res     (cnt)
    );

    // byte class decode
    always_comb begin
        unique case (i_rx_byte)
            efd_pkg::MARK_ESC,
            efd_pkg::MARK_START,
            efd_pkg::MARK_END: is_ordinary = 1'b0;
            default:           is_ordinary = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_idx   = r_idx;
        n_esc   = r_esc;
        unique case (r_state)
            efd_pkg::ST_IDLE: begin
                if (i_rx_valid) begin
                    unique case (i_rx_byte)
                        efd_pkg::MARK_ESC: begin
                            n_esc = 1'b1;
                        end
                        efd_pkg::MARK_START: begin
                            n_len = 7'd0;
                            n_esc = 1'b0;
                        end
                        efd_pkg::MARK_END: begin
                            n_esc = 1'b0;
                            if (r_len >= 7'd2) begin
                                n_idx   = 7'd0;
                                n_state = efd_pkg::ST_READ;
                            end else begin
                                n_len = 7'd0;
                            end
                        end
                        default: begin
                            n_esc = 1'b0;
                            // overflow drops the frame
                            n_len = cnt.reach ? 7'd0 : cnt.sum;
                        end
                    endcase
                end
            end
            efd_pkg::ST_READ: begin
                n_state = efd_pkg::ST_HOLD;
            end
            efd_pkg::ST_HOLD: begin
                if (i_out_ready) begin
                    if (cnt.hit) begin
                        n_len   = 7'd0;
                        n_state = efd_pkg::ST_IDLE;
                    end else begin
                        n_idx   = cnt.sum;
                        n_state = efd_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = efd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_rx_ready   = (r_state == efd_pkg::ST_IDLE);
        o_out_valid  = (r_state == efd_pkg::ST_HOLD);
        o_we         = i_rx_valid && (r_state == efd_pkg::ST_IDLE) && is_ordinary;
        o_wdata      = r_esc ? (i_rx_byte ^ efd_pkg::ESC_FLIP) : i_rx_byte;
        o_waddr      = r_len[ADDR_W-1:0];
        o_raddr      = r_idx[ADDR_W-1:0];
        o_byte_index = r_idx[5:0];
        o_frame_last = cnt.hit;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efd_pkg::ST_IDLE;
            r_len   <= 7'd0;
            r_idx   <= 7'd0;
            r_esc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_esc   <= n_esc;
        end
    end

    // a readout only runs for frames of two or more bytes, with the index inside the frame
    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_len >= 7'd2 && r_idx < r_len))
        else $error("readout of a short frame or index past frame end");

    // final beat clears the stored length and the escape flag
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_frame_last) |=> (r_len == 7'd0 && !r_esc))
        else $error("store not cleared after final beat");

    // a readout beat that is not last moves to the next byte
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_frame_last) |=> (r_idx == $past(r_idx) + 7'd1))
        else $error("readout index did not advance by one");

    // writes only while collecting and inside the store
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == efd_pkg::ST_IDLE && r_len < 7'(MEM_DEPTH)))
        else $error("store write outside collection or past store end");

endmodule

FILE: rtl/core/escaped_frame_deframer.sv
// Byte-unstuffing frame receiver. Line bytes arrive on the rx channel, one per
// cycle while collecting: 0x7E starts a frame, 0x7D escapes the next byte
// (stored XOR 0x20), 0x7F ends the frame, anything else is stored. A frame
// whose stored length reaches frame_limit (capped at the store depth and 64)
// is dropped. An end marker with two or more stored bytes starts a readout
// in which each byte is sent as one output beat with its index and a last
// flag; each byte passes through a store read state and then a hold state
// until taken, and the rx channel is held off while the readout runs. The
// store is one single-port-write, registered-read memory read by the
// readout sequencer; it needs no clearing pass after reset.
module escaped_frame_deframer #(
    parameter int STORE_DEPTH = efd_pkg::STORE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_frame_byte,
    output logic [5:0] o_byte_index,
    output logic       o_frame_last
);

    localparam int MEM_DEPTH = (STORE_DEPTH < efd_pkg::MAX_FRAME) ?
                               STORE_DEPTH : efd_pkg::MAX_FRAME;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [6:0] LIM_MAX = 7'(MEM_DEPTH);

    logic [6:0]        r_frame_limit;
    logic [6:0]        limit;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        wdata;

    // frame limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= efd_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_frame_limit <= i_cfg_wdata;
        end
    end

    // effective limit, capped at the store depth
    assign limit = (r_frame_limit > LIM_MAX) ? LIM_MAX : r_frame_limit;

    efd_seq #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_limit      (limit),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_byte_index (o_byte_index),
        .o_frame_last (o_frame_last),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr      (raddr)
    );

    efd_store #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (o_frame_byte)
    );

endmodule
